>>> hw/rtl/dwrc_pkg.sv
package dwrc_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CrcW = 32;
  localparam int unsigned HalfW = 16;
  localparam int unsigned ByteW = 8;

  localparam logic [CfgIdxW-1:0] CfgCrcMode = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPolySixteen = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPolyThirtytwo = 2'd2;

  localparam logic [HalfW-1:0] PolySixteenRst = 16'hBAAD;
  localparam logic [CrcW-1:0] PolyThirtytwoRst = 32'h5AA5A55A;
  localparam logic [CrcW-1:0] StartThirtytwo = 32'hFFFF_FFFF;
  localparam logic [CrcW-1:0] FinalInvert = 32'hFFFF_FFFF;

  typedef logic [CrcW-1:0] crc_t;

  // lsb-first fold of one byte, one polynomial step per bit
  function automatic crc_t fold_byte(crc_t rem_in, logic [ByteW-1:0] data, crc_t poly);
    crc_t rem;
    rem = rem_in ^ {{(CrcW-ByteW){1'b0}}, data};
    for (int k = 0; k < ByteW; k++) begin
      if (rem[0]) begin
        rem = (rem >> 1) ^ poly;
      end else begin
        rem = rem >> 1;
      end
    end
    return rem;
  endfunction

endpackage

>>> hw/rtl/dual_width_reflected_crc_top.sv
// a last or empty word is held in the input register, then its crc in the result register
// throughput: one word per cycle unless a last or empty word waits; the byte fold is one registered xor stage
// a last or empty word waits in the input register while an earlier crc is held
// reset: asynchronous active low; clears the pipe valids and the running crc,
// selects 16-bit mode and restores both default polynomials
module dual_width_reflected_crc_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [7:0]                     data_byte_i,
  input  logic                           first_byte_i,
  input  logic                           last_byte_i,
  input  logic                           empty_message_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [31:0]                    crc_value_o,
  input  logic                           cfg_we_i,
  input  logic [dwrc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [dwrc_pkg::CfgDataW-1:0]  cfg_data_i
);

  logic                    crc_mode_q;
  logic [15:0]             poly_sixteen_q;
  dwrc_pkg::crc_t          poly_thirtytwo_q;
  dwrc_pkg::crc_t          running_crc_q, running_crc_d;

  logic                    s1_valid_q;
  logic [7:0]              s1_byte_q;
  logic                    s1_first_q;
  logic                    s1_last_q;
  logic                    s1_empty_q;

  logic                    out_valid_q, out_valid_d;
  dwrc_pkg::crc_t          crc_value_q, crc_value_d;

  logic                    s1_has_result;
  logic                    s1_advance;
  dwrc_pkg::crc_t          start_rem;
  dwrc_pkg::crc_t          sel_poly;
  dwrc_pkg::crc_t          fold_rem;
  dwrc_pkg::crc_t          new_rem;
  dwrc_pkg::crc_t          final_crc;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_mode_q       <= 1'b0;
      poly_sixteen_q   <= dwrc_pkg::PolySixteenRst;
      poly_thirtytwo_q <= dwrc_pkg::PolyThirtytwoRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        dwrc_pkg::CfgCrcMode:       crc_mode_q       <= cfg_data_i[0];
        dwrc_pkg::CfgPolySixteen:   poly_sixteen_q   <= cfg_data_i[15:0];
        dwrc_pkg::CfgPolyThirtytwo: poly_thirtytwo_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign s1_has_result = s1_empty_q | s1_last_q;
  assign s1_advance    = s1_valid_q & (~s1_has_result | ~out_valid_q | out_ready_i);
  assign in_ready_o    = ~s1_valid_q | s1_advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_byte_q  <= data_byte_i;
      s1_first_q <= first_byte_i;
      s1_last_q  <= last_byte_i;
      s1_empty_q <= empty_message_i;
    end
  end

  // byte fold against the running remainder
  always_comb begin
    if (crc_mode_q) begin
      start_rem = s1_first_q ? dwrc_pkg::StartThirtytwo : running_crc_q;
      sel_poly  = poly_thirtytwo_q;
    end else begin
      start_rem = s1_first_q ? '0 : {16'h0000, running_crc_q[15:0]};
      sel_poly  = {16'h0000, poly_sixteen_q};
    end
    fold_rem = dwrc_pkg::fold_byte(start_rem, s1_byte_q, sel_poly);
    new_rem  = crc_mode_q ? fold_rem : {16'h0000, fold_rem[15:0]};
    final_crc = crc_mode_q ? (new_rem ^ dwrc_pkg::FinalInvert) : new_rem;
  end

  always_comb begin
    running_crc_d = running_crc_q;
    if (s1_advance && !s1_empty_q) begin
      running_crc_d = new_rem;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_crc_q <= '0;
    end else begin
      running_crc_q <= running_crc_d;
    end
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    crc_value_d = crc_value_q;
    if (s1_advance && s1_has_result) begin
      out_valid_d = 1'b1;
      crc_value_d = s1_empty_q ? '0 : final_crc;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    crc_value_q <= crc_value_d;
  end

  assign out_valid_o = out_valid_q;
  assign crc_value_o = crc_value_q;

endmodule

>>> hw/rtl/dwrc_checker.sv
module dwrc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] crc_value_o
);

  // held result keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(crc_value_o))
    else $error("stalled crc word changed");

  // no result shows while reset is applied
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

  // input only stalls behind a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled with free output");

  // a fresh result comes from an input word taken through the input and result registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without a matching input word");

endmodule

bind dual_width_reflected_crc_top dwrc_checker u_dwrc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .crc_value_o (crc_value_o)
);

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int unsigned PipeDrain = 6;
  localparam int unsigned PhaseWords = 215;
  localparam int unsigned SteadyWords = 200;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic [dwrc_pkg::ByteW-1:0]    data_byte_i;
  logic                          first_byte_i;
  logic                          last_byte_i;
  logic                          empty_message_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic [dwrc_pkg::CrcW-1:0]     crc_value_o;
  logic                          cfg_we_i;
  logic [dwrc_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [dwrc_pkg::CfgDataW-1:0] cfg_data_i;

  // shadow copy of the block's registers and remainder
  logic                          mode_wide;
  logic [dwrc_pkg::HalfW-1:0]    poly_short;
  logic [dwrc_pkg::CrcW-1:0]     poly_long;
  logic [dwrc_pkg::CrcW-1:0]     crc_run;

  dwrc_pkg::crc_t      crc_expect_q[$];
  int unsigned         errors = 0;
  int unsigned         words_sent = 0;
  bit                  gaps_on = 1'b1;

  dual_width_reflected_crc_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .data_byte_i     (data_byte_i),
    .first_byte_i    (first_byte_i),
    .last_byte_i     (last_byte_i),
    .empty_message_i (empty_message_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .crc_value_o     (crc_value_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // lsb-first shift: the polynomial is xored in whenever a one drops out
  function automatic logic [dwrc_pkg::CrcW-1:0] shift_in_byte(
      logic [dwrc_pkg::CrcW-1:0] rem_in,
      logic [dwrc_pkg::ByteW-1:0] b,
      logic [dwrc_pkg::CrcW-1:0] poly);
    logic [dwrc_pkg::CrcW-1:0] acc;
    logic                      drop;
    acc = rem_in;
    acc[dwrc_pkg::ByteW-1:0] = acc[dwrc_pkg::ByteW-1:0] ^ b;
    for (int k = 0; k < dwrc_pkg::ByteW; k++) begin
      drop = acc[0];
      acc = {1'b0, acc[dwrc_pkg::CrcW-1:1]} ^ (poly & {dwrc_pkg::CrcW{drop}});
    end
    return acc;
  endfunction

  task automatic track_crc(logic [dwrc_pkg::ByteW-1:0] b, logic f, logic l, logic e);
    logic [dwrc_pkg::CrcW-1:0] rem;
    if (e) begin
      crc_expect_q.push_back('0);
      return;
    end
    if (mode_wide) begin
      rem = f ? dwrc_pkg::StartThirtytwo : crc_run;
      rem = shift_in_byte(rem, b, poly_long);
    end else begin
      rem = f ? '0 : {{(dwrc_pkg::CrcW-dwrc_pkg::HalfW){1'b0}}, crc_run[dwrc_pkg::HalfW-1:0]};
      rem = shift_in_byte(rem, b, {{(dwrc_pkg::CrcW-dwrc_pkg::HalfW){1'b0}}, poly_short});
      rem[dwrc_pkg::CrcW-1:dwrc_pkg::HalfW] = '0;
    end
    crc_run = rem;
    if (l) begin
      crc_expect_q.push_back(mode_wide ? (rem ^ dwrc_pkg::FinalInvert) : rem);
    end
  endtask

  task automatic report_mismatch(string what, dwrc_pkg::crc_t got, dwrc_pkg::crc_t want);
    errors++;
    $display("mismatch: %s got %08h want %08h", what, got, want);
  endtask

  // valid is lowered only ahead of a gap, so it never drops and rises in one step
  task automatic send_word(logic [dwrc_pkg::ByteW-1:0] b, logic f, logic l, logic e);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    data_byte_i     <= b;
    first_byte_i    <= f;
    last_byte_i     <= l;
    empty_message_i <= e;
    do @(posedge clk_i); while (!in_ready_o);
    track_crc(b, f, l, e);
    words_sent++;
  endtask

  // hold off until every crc has come out and the pipe has emptied
  task automatic settle();
    in_valid_i <= 1'b0;
    while (crc_expect_q.size() != 0) @(posedge clk_i);
    repeat (PipeDrain) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [dwrc_pkg::CfgIdxW-1:0] idx,
                           logic [dwrc_pkg::CfgDataW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    case (idx)
      dwrc_pkg::CfgCrcMode: begin
        mode_wide = value[0];
      end
      dwrc_pkg::CfgPolySixteen: begin
        poly_short = value[dwrc_pkg::HalfW-1:0];
      end
      dwrc_pkg::CfgPolyThirtytwo: begin
        poly_long = value;
      end
      default: begin
      end
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_random_message();
    int unsigned len;
    int unsigned split_at;
    if ($urandom_range(0, 9) < 2) begin
      // stray word with arbitrary marks
      send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
      return;
    end
    len = ($urandom_range(0, 29) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
    split_at = (len > 1 && $urandom_range(0, 19) == 0) ? $urandom_range(1, len - 1) : 0;
    for (int unsigned i = 0; i < len; i++) begin
      if (split_at != 0 && i == split_at) begin
        settle();
        write_reg(dwrc_pkg::CfgCrcMode, $urandom);
      end
      if ($urandom_range(0, 39) == 0) begin
        send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'b1);
      end
      send_word(8'($urandom_range(0, 255)), i == 0, i == len - 1, 1'b0);
    end
  endtask

  // receiver stalls in bursts while gaps are enabled
  initial begin
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(0, 12)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (crc_expect_q.size() == 0) begin
        report_mismatch("crc word with none expected", crc_value_o, '0);
      end else begin
        if (crc_value_o !== crc_expect_q[0]) begin
          report_mismatch("crc_value", crc_value_o, crc_expect_q[0]);
        end
        void'(crc_expect_q.pop_front());
      end
    end
  end

  // bytes with no first mark right after reset continue from zero
  task automatic test_reset_continue();
    send_word(8'hA5, 1'b0, 1'b1, 1'b0);
  endtask

  task automatic test_sixteen_messages();
    send_word(8'hFF, 1'b1, 1'b1, 1'b1);
    send_word(8'h00, 1'b1, 1'b1, 1'b0);
    send_word(8'hFF, 1'b1, 1'b1, 1'b0);
    send_word(8'h00, 1'b1, 1'b0, 1'b0);
    send_word(8'h80, 1'b0, 1'b0, 1'b0);
    // empty message in the middle must leave the remainder alone
    send_word(8'h3C, 1'b1, 1'b1, 1'b1);
    send_word(8'hFF, 1'b0, 1'b1, 1'b0);
  endtask

  task automatic test_thirtytwo_and_switch();
    settle();
    write_reg(dwrc_pkg::CfgCrcMode, 32'h1);
    send_word(8'hFF, 1'b1, 1'b1, 1'b0);
    send_word(8'h00, 1'b1, 1'b1, 1'b0);
    send_word(8'h5A, 1'b1, 1'b0, 1'b0);
    settle();
    write_reg(dwrc_pkg::CfgCrcMode, 32'hFFFF_FFFE);
    send_word(8'h3C, 1'b0, 1'b1, 1'b0);
    send_word(8'hC3, 1'b1, 1'b0, 1'b0);
    settle();
    write_reg(dwrc_pkg::CfgCrcMode, 32'h1);
    send_word(8'h01, 1'b0, 1'b1, 1'b0);
  endtask

  task automatic test_poly_extremes();
    settle();
    write_reg(dwrc_pkg::CfgCrcMode, 32'h0);
    write_reg(dwrc_pkg::CfgPolySixteen, 32'hA5A5_FFFF);
    send_word(8'h01, 1'b1, 1'b1, 1'b0);
    settle();
    write_reg(dwrc_pkg::CfgPolySixteen, 32'h0);
    send_word(8'hFE, 1'b1, 1'b1, 1'b0);
    settle();
    write_reg(dwrc_pkg::CfgCrcMode, 32'h1);
    write_reg(dwrc_pkg::CfgPolyThirtytwo, 32'hFFFF_FFFF);
    send_word(8'h80, 1'b1, 1'b1, 1'b0);
    settle();
    write_reg(dwrc_pkg::CfgPolyThirtytwo, 32'h0);
    send_word(8'h7E, 1'b1, 1'b1, 1'b0);
  endtask

  task automatic test_random_phases();
    logic [dwrc_pkg::CfgDataW-1:0] p16;
    logic [dwrc_pkg::CfgDataW-1:0] p32;
    logic [dwrc_pkg::CfgDataW-1:0] mode_word;
    logic                          wide;
    int unsigned                   stop_at;
    for (int ph = 0; ph < 7; ph++) begin
      wide = 1'($urandom_range(0, 1));
      p16  = $urandom;
      p32  = $urandom;
      case (ph)
        0: begin
          wide = 1'b0;
          p16  = 32'hFFFF;
        end
        1: begin
          wide = 1'b1;
          p32  = 32'hFFFF_FFFF;
        end
        2: begin
          wide = 1'b0;
          p16  = 32'h0;
        end
        3: begin
          wide = 1'b1;
          p32  = 32'h0;
        end
        4: begin
          p16 = {16'h0, dwrc_pkg::PolySixteenRst};
          p32 = dwrc_pkg::PolyThirtytwoRst;
        end
        default: begin
        end
      endcase
      settle();
      write_reg(dwrc_pkg::CfgPolySixteen, p16);
      write_reg(dwrc_pkg::CfgPolyThirtytwo, p32);
      mode_word    = $urandom;
      mode_word[0] = wide;
      write_reg(dwrc_pkg::CfgCrcMode, mode_word);
      stop_at = words_sent + PhaseWords;
      while (words_sent < stop_at) send_random_message();
    end
  endtask

  // back-to-back traffic, no stalls on either side
  task automatic test_steady_stream();
    int unsigned stop_at;
    settle();
    gaps_on = 1'b0;
    write_reg(dwrc_pkg::CfgCrcMode, $urandom);
    stop_at = words_sent + SteadyWords;
    while (words_sent < stop_at) send_random_message();
  endtask

  initial begin
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    data_byte_i     <= '0;
    first_byte_i    <= 1'b0;
    last_byte_i     <= 1'b0;
    empty_message_i <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_index_i     <= dwrc_pkg::CfgCrcMode;
    cfg_data_i      <= '0;
    mode_wide  = 1'b0;
    poly_short = dwrc_pkg::PolySixteenRst;
    poly_long  = dwrc_pkg::PolyThirtytwoRst;
    crc_run    = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_continue();
    test_sixteen_messages();
    test_thirtytwo_and_switch();
    test_poly_extremes();
    test_random_phases();
    test_steady_stream();
    settle();

    if (errors == 0) begin
      $display("[dual_width_reflected_crc_top] OK");
    end else begin
      $display("[dual_width_reflected_crc_top] ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[dual_width_reflected_crc_top] ERROR");
    $finish;
  end

endmodule

>>> dual_width_reflected_crc_top.f
hw/rtl/dwrc_pkg.sv
hw/rtl/dual_width_reflected_crc_top.sv
hw/rtl/dwrc_checker.sv
test/tb.sv
